@@ design/motor_duty_soft_start_ramp_top_macros.svh @@
// Assertion macros for the motor duty soft-start ramp block.
// Each macro expects clk and rst in scope; rst masks the check.
`ifndef MOTOR_DUTY_SOFT_START_RAMP_TOP_MACROS_SVH
`define MOTOR_DUTY_SOFT_START_RAMP_TOP_MACROS_SVH

// Plain property, sampled on the rising edge, masked during reset
`define MDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define MDR_ASSERT_IMPL(label, ante, cons, msg) \
  `MDR_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define MDR_ASSERT_NEXT(label, ante, cons, msg) \
  `MDR_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ design/mdr_pkg.sv @@
// Shared types and constants of the motor duty soft-start ramp block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mdr_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [1:0] REG_SOFT_MAX  = 2'd1;
  localparam logic [1:0] REG_RAMP_STEP = 2'd2;

  // Register reset values
  localparam logic [6:0] DEAD_ZONE_RESET = 7'd10;
  localparam logic [6:0] SOFT_MAX_RESET  = 7'd90;
  localparam logic [7:0] RAMP_STEP_RESET = 8'd5;

  // Arithmetic constants
  localparam logic [7:0] MIN_STEP_SIZE = 8'd5;
  localparam logic [7:0] PCT_CLAMP     = 8'd100;

  // Divide by 100 as a multiply by ceil(2^22 / 100) and a shift;
  // exact for every numerator below 43690
  localparam logic [15:0] DIV100_MUL   = 16'd41944;
  localparam int          DIV100_SHIFT = 22;

  // Serial divider geometry
  localparam int DIV_W   = 16;
  localparam int DIVR_W  = 8;
  localparam int DCNT_W  = 5;

  // Command queue geometry
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  // Configuration write beat
  typedef struct packed {
    logic       we;
    logic [1:0] index;
    logic [7:0] data;
  } cfg_wr_t;

  // Classified command between front and back
  typedef struct packed {
    logic       zero;
    logic [6:0] pct;
  } mdr_item_t;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

endpackage

@@ design/mdr_div.sv @@
// Shared restoring divider: one quotient bit per cycle.
// Depends on mdr_pkg for its widths and request struct.
`timescale 1ns / 1ps

module mdr_div (
  input  logic                     clk,
  input  logic                     rst,
  input  mdr_pkg::div_req_t        req,
  output logic                     busy,
  output logic [mdr_pkg::DIV_W-1:0] quotient
);
  import mdr_pkg::*;

  logic [DIVR_W-1:0] rem;
  logic [DIVR_W-1:0] divisor;
  logic [DCNT_W-1:0] count;
  logic [DIVR_W:0]   partial;
  logic [DIVR_W:0]   trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    partial = {rem, quotient[DIV_W-1]};
    trial   = partial - {1'b0, divisor};
    fits    = partial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (req.start) begin
      quotient <= req.dividend;
      divisor  <= req.divisor;
      rem      <= '0;
      count    <= DCNT_W'(DIV_W);
      busy     <= 1'b1;
    end else if (busy) begin
      rem      <= fits ? trial[DIVR_W-1:0] : partial[DIVR_W-1:0];
      quotient <= {quotient[DIV_W-2:0], fits};
      count    <= count - 1'b1;
      if (count == DCNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ design/mdr_front.sv @@
// Front end: clamps the target percent, classifies it and queues it.
// Depends on mdr_pkg for the queue item type and depth.
`timescale 1ns / 1ps

module mdr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [7:0]  target_percent,
  output logic               q_valid,
  output mdr_pkg::mdr_item_t q_item,
  input  logic               q_pop
);
  import mdr_pkg::*;

  mdr_item_t            entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  mdr_item_t            item_in;
  logic                 push;

  // Clamp to 0..100 and flag a stop command
  always_comb begin
    if (target_percent[7]) begin
      item_in.pct = '0;
    end else if (8'(target_percent) > PCT_CLAMP) begin
      item_in.pct = PCT_CLAMP[6:0];
    end else begin
      item_in.pct = target_percent[6:0];
    end
    item_in.zero = (item_in.pct == '0);
  end

  assign in_stall = (count == Q_CNT_W'(Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = entries[rd_ptr];

  // Store on push, advance the read side on pop
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= Q_PTR_W'(wr_ptr + 1'b1);
      end
      if (q_pop) begin
        rd_ptr <= Q_PTR_W'(rd_ptr + 1'b1);
      end
      count <= Q_CNT_W'(count + Q_CNT_W'(push) - Q_CNT_W'(q_pop));
    end
  end

endmodule

@@ design/mdr_back.sv @@
// Back end: duty mapping, ramp sequencing, register file and output beat.
// Depends on mdr_pkg; drives the shared divider mdr_div.
`timescale 1ns / 1ps

module mdr_back #(
  parameter int FULL_SCALE_DUTY = 255
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mdr_pkg::cfg_wr_t          cfg,
  input  logic                      q_valid,
  input  mdr_pkg::mdr_item_t        q_item,
  output logic                      q_pop,
  output mdr_pkg::div_req_t         div_req,
  input  logic                      div_busy,
  input  logic [mdr_pkg::DIV_W-1:0] div_quotient,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                duty,
  output logic                      drive_forward,
  output logic [6:0]                speed_now,
  output logic                      last_of_run
);
  import mdr_pkg::*;

  localparam logic [7:0] DUTY_MAX = 8'(FULL_SCALE_DUTY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_NEW_A = 3'd1;
  localparam logic [2:0] S_NEW_B = 3'd2;
  localparam logic [2:0] S_OLD_A = 3'd3;
  localparam logic [2:0] S_OLD_B = 3'd4;
  localparam logic [2:0] S_STEPS = 3'd5;
  localparam logic [2:0] S_RAMP  = 3'd6;
  localparam logic [2:0] S_LAST  = 3'd7;

  logic [2:0]  state;
  logic        pend;
  logic [6:0]  dead_zone_percent;
  logic [6:0]  soft_max_percent;
  logic [7:0]  ramp_step_size;
  logic [6:0]  speed_percent;
  logic [6:0]  cur_pct;
  logic [6:0]  scaled;
  logic [7:0]  new_duty;
  logic [7:0]  old_duty;
  logic [7:0]  diff;
  logic [5:0]  steps;
  logic [5:0]  idx;
  logic [14:0] num;

  logic [6:0]  calc_pct;
  logic        in_dead;
  logic [13:0] prod_a;
  logic [14:0] prod_b;
  logic [13:0] prod_r;
  logic [30:0] recip;
  logic [8:0]  q100;
  logic [7:0]  step_eff;
  logic [7:0]  duty_sat;
  logic        div_done;
  logic        out_free;

  // Operands for the current step; num / 100 by reciprocal multiply
  always_comb begin
    calc_pct = (state == S_OLD_A) ? speed_percent : cur_pct;
    in_dead  = calc_pct < dead_zone_percent;
    prod_a   = calc_pct * soft_max_percent;
    prod_b   = scaled * DUTY_MAX;
    prod_r   = diff * idx;
    recip    = 31'(num) * 31'(DIV100_MUL);
    q100     = recip[DIV100_SHIFT +: 9];
    step_eff = (ramp_step_size < MIN_STEP_SIZE) ? MIN_STEP_SIZE : ramp_step_size;
    duty_sat = (q100 > {1'b0, DUTY_MAX}) ? DUTY_MAX : q100[7:0];
    div_done = pend && !div_busy;
    out_free = !out_valid || !out_stall;
    q_pop    = (state == S_IDLE) && q_valid;
  end

  // Divider request for the step count and each ramp beat
  always_comb begin
    div_req = '0;
    unique case (state)
      S_STEPS: begin
        div_req.start    = !pend && (new_duty > old_duty);
        div_req.dividend = DIV_W'(new_duty - old_duty);
        div_req.divisor  = step_eff;
      end
      S_RAMP: begin
        div_req.start    = !pend;
        div_req.dividend = DIV_W'(prod_r);
        div_req.divisor  = DIVR_W'(steps);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone_percent <= DEAD_ZONE_RESET;
      soft_max_percent  <= SOFT_MAX_RESET;
      ramp_step_size    <= RAMP_STEP_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_DEAD_ZONE: dead_zone_percent <= cfg.data[6:0];
        REG_SOFT_MAX:  soft_max_percent  <= cfg.data[6:0];
        REG_RAMP_STEP: ramp_step_size    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Sequencer and output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pend          <= 1'b0;
      out_valid     <= 1'b0;
      speed_percent <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (div_req.start) begin
        pend <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_pct <= q_item.pct;
            if (q_item.zero) begin
              new_duty <= '0;
              state    <= S_LAST;
            end else begin
              state <= S_NEW_A;
            end
          end
        end
        S_NEW_A: begin
          if (!pend) begin
            if (in_dead) begin
              new_duty <= '0;
              state    <= S_OLD_A;
            end else begin
              num  <= {1'b0, prod_a};
              pend <= 1'b1;
            end
          end else begin
            scaled <= q100[6:0];
            pend   <= 1'b0;
            state  <= S_NEW_B;
          end
        end
        S_NEW_B: begin
          if (!pend) begin
            num  <= prod_b;
            pend <= 1'b1;
          end else begin
            new_duty <= duty_sat;
            pend     <= 1'b0;
            state    <= S_OLD_A;
          end
        end
        S_OLD_A: begin
          if (!pend) begin
            if (in_dead) begin
              old_duty <= '0;
              state    <= S_STEPS;
            end else begin
              num  <= {1'b0, prod_a};
              pend <= 1'b1;
            end
          end else begin
            scaled <= q100[6:0];
            pend   <= 1'b0;
            state  <= S_OLD_B;
          end
        end
        S_OLD_B: begin
          if (!pend) begin
            num  <= prod_b;
            pend <= 1'b1;
          end else begin
            old_duty <= duty_sat;
            pend     <= 1'b0;
            state    <= S_STEPS;
          end
        end
        S_STEPS: begin
          if (!pend) begin
            diff <= new_duty - old_duty;
            if (new_duty <= old_duty) begin
              state <= S_LAST;
            end
          end else if (div_done) begin
            // at least one ramp step
            steps <= (div_quotient[5:0] == '0) ? 6'd1 : div_quotient[5:0];
            idx   <= 6'd1;
            pend  <= 1'b0;
            state <= S_RAMP;
          end
        end
        S_RAMP: begin
          if (div_done && out_free) begin
            duty          <= old_duty + div_quotient[7:0];
            drive_forward <= 1'b1;
            speed_now     <= cur_pct;
            last_of_run   <= 1'b0;
            out_valid     <= 1'b1;
            pend          <= 1'b0;
            if (idx == steps) begin
              state <= S_LAST;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_LAST: begin
          if (out_free) begin
            duty          <= new_duty;
            drive_forward <= (cur_pct != '0);
            speed_now     <= cur_pct;
            last_of_run   <= 1'b1;
            out_valid     <= 1'b1;
            speed_percent <= cur_pct;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/motor_duty_soft_start_ramp_top.sv @@
// Motor duty soft-start ramp generator, top level.
//
// Input channel: in_valid / in_stall carry one signed target_percent per
// beat. It is clamped to 0..100 and placed in a two-entry command queue,
// so two commands can wait while the back end works.
// Output channel: out_valid / out_stall carry duty, drive_forward,
// speed_now and last_of_run. A stop command gives one beat; a rising duty
// gives a ramp of beats closed by the final duty with last_of_run set.
// A stop command goes straight to its final beat. Any other command
// maps both percents to duty with up to four divisions by 100, each a
// reciprocal multiply on a registered numerator, and a drop or an equal
// duty then gives its final beat. A rise adds a step-count division and
// one division per ramp beat on the 16-step serial divider; a run has at
// most 52 beats. The serial divider sets the ramp beat rate; the back end
// takes the next command from the queue only after the final beat.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 dead zone, 1 soft maximum, 2 ramp step); write only while idle.
// Reset (rst, synchronous) empties the queue, clears the stored speed and
// restores register defaults. While out_stall is high the pending beat is
// held and the next beat waits; the queue keeps taking commands until full.
`timescale 1ns / 1ps
`include "motor_duty_soft_start_ramp_top_macros.svh"

module motor_duty_soft_start_ramp_top #(
  parameter int FULL_SCALE_DUTY = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [7:0] target_percent,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        duty,
  output logic              drive_forward,
  output logic [6:0]        speed_now,
  output logic              last_of_run
);
  import mdr_pkg::*;

  cfg_wr_t          cfg;
  logic             q_valid;
  mdr_item_t        q_item;
  logic             q_pop;
  div_req_t         div_req;
  logic             div_busy;
  logic [DIV_W-1:0] div_quotient;

  assign cfg = '{we: cfg_we, index: cfg_index, data: cfg_data};

  mdr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_percent (target_percent),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  mdr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  mdr_back #(
    .FULL_SCALE_DUTY (FULL_SCALE_DUTY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .div_req       (div_req),
    .div_busy      (div_busy),
    .div_quotient  (div_quotient),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .duty          (duty),
    .drive_forward (drive_forward),
    .speed_now     (speed_now),
    .last_of_run   (last_of_run)
  );

  // A stop beat is a single, final, zero beat
  `MDR_ASSERT_IMPL(a_stop_beat, out_valid && !drive_forward,
                   duty == 8'd0 && speed_now == 7'd0 && last_of_run,
                   "stop beat carries duty or speed")
  // Ramp beats always drive forward and stay within full scale
  `MDR_ASSERT_IMPL(a_ramp_fwd, out_valid && !last_of_run,
                   drive_forward && duty <= 8'(FULL_SCALE_DUTY), "ramp beat out of range")
  // Duty never falls within a ramp
  `MDR_ASSERT_NEXT(a_ramp_rise, out_valid && !out_stall && !last_of_run,
                   !out_valid || duty >= $past(duty), "ramp duty fell")
  // Speed stays within 0..100
  `MDR_ASSERT_IMPL(a_speed_range, out_valid, speed_now <= 7'd100, "speed out of range")

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the motor duty soft-start ramp block.
// Depends on mdr_pkg and motor_duty_soft_start_ramp_top; predicts every duty beat
// in order and compares it with what the block sends, under random idling.
`timescale 1ns / 1ps

module tb_top;
  import mdr_pkg::*;

  localparam int unsigned FSD = 255;
  localparam int unsigned RANDOM_ITEMS = 345;
  localparam int unsigned PHASE_ITEMS = 62;
  localparam longint unsigned CYCLE_LIMIT = 2_500_000;

  // Expected output beat
  typedef struct packed {
    logic [7:0] duty;
    logic       fwd;
    logic [6:0] spd;
    logic       last;
  } duty_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_index = REG_DEAD_ZONE;
  logic [7:0]        cfg_data = 8'd0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic signed [7:0] target_percent = 8'sd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [7:0]        duty;
  logic              drive_forward;
  logic [6:0]        speed_now;
  logic              last_of_run;

  // Predictor state and register copies
  logic [6:0] dead_zone_m;
  logic [6:0] soft_max_m;
  logic [7:0] step_m;
  logic [6:0] speed_m;

  duty_beat_t duty_beats_q[$];
  int unsigned errors = 0;
  int unsigned items_accepted = 0;
  int unsigned beats_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned stall_left = 0;
  bit idling_on = 1'b0;
  longint unsigned cycle_count = 0;

  motor_duty_soft_start_ramp_top dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .target_percent (target_percent),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .duty           (duty),
    .drive_forward  (drive_forward),
    .speed_now      (speed_now),
    .last_of_run    (last_of_run)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Map a percent to duty with the current register copies
  function automatic int unsigned duty_of_pct(input int unsigned pct);
    int unsigned scaled;
    int unsigned d;
    if (pct < dead_zone_m) return 0;
    scaled = (pct * soft_max_m) / 100;
    d = (scaled * FSD) / 100;
    if (d > FSD) d = FSD;
    return d;
  endfunction

  // Queue the beats that one accepted target causes and advance the speed
  function automatic void predict_ramp(input logic [7:0] raw);
    int unsigned pct;
    int unsigned new_duty;
    int unsigned old_duty;
    int unsigned step;
    int unsigned diff;
    int unsigned steps;
    duty_beat_t b;
    if (raw[7]) pct = 0;
    else if (raw > 8'd100) pct = 100;
    else pct = 32'(raw);
    if (pct == 0) begin
      speed_m = 7'd0;
      b = '{duty: 8'd0, fwd: 1'b0, spd: 7'd0, last: 1'b1};
      duty_beats_q.push_back(b);
      return;
    end
    new_duty = duty_of_pct(pct);
    old_duty = duty_of_pct(32'(speed_m));
    step = 32'((step_m < MIN_STEP_SIZE) ? MIN_STEP_SIZE : step_m);
    if (new_duty > old_duty) begin
      diff = new_duty - old_duty;
      steps = diff / step;
      if (steps < 1) steps = 1;
      for (int unsigned i = 1; i <= steps; i++) begin
        b.duty = 8'(old_duty + (diff * i) / steps);
        b.fwd = 1'b1;
        b.spd = 7'(pct);
        b.last = 1'b0;
        duty_beats_q.push_back(b);
      end
    end
    b = '{duty: 8'(new_duty), fwd: 1'b1, spd: 7'(pct), last: 1'b1};
    duty_beats_q.push_back(b);
    speed_m = 7'(pct);
  endfunction

  // Record every accepted target
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_ramp(target_percent);
      items_accepted++;
    end
  end

  // Compare every accepted output beat with the oldest expectation
  always @(posedge clk) begin
    duty_beat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (duty_beats_q.size() == 0) begin
        $display("%0t: unexpected beat duty=%0d fwd=%0d spd=%0d last=%0d", $time,
                 duty, drive_forward, speed_now, last_of_run);
        errors++;
      end else begin
        e = duty_beats_q.pop_front();
        beats_checked++;
        if (duty !== e.duty) begin
          $display("%0t: duty expected %0d actual %0d", $time, e.duty, duty);
          errors++;
        end
        if (drive_forward !== e.fwd) begin
          $display("%0t: drive_forward expected %0d actual %0d", $time, e.fwd,
                   drive_forward);
          errors++;
        end
        if (speed_now !== e.spd) begin
          $display("%0t: speed_now expected %0d actual %0d", $time, e.spd, speed_now);
          errors++;
        end
        if (last_of_run !== e.last) begin
          $display("%0t: last_of_run expected %0d actual %0d", $time, e.last,
                   last_of_run);
          errors++;
        end
      end
    end
  end

  // Receiver: stall at random while idling is on
  always @(posedge clk) begin
    if (rst || !idling_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, duty_beats_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Present one target and hold it until the block takes it
  task automatic send_target(input logic [7:0] t);
    int unsigned gap;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target_percent <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every expected beat has arrived
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (duty_beats_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write one register and mirror it into the predictor
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DEAD_ZONE: dead_zone_m = val[6:0];
      REG_SOFT_MAX:  soft_max_m = val[6:0];
      REG_RAMP_STEP: step_m = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Default registers: clamping, dead zone edges, stop, rise, drop and hold
  task automatic test_defaults();
    send_target(8'd100);
    send_target(8'd127);
    send_target(8'd50);
    send_target(8'h80);
    send_target(8'd9);
    send_target(8'd10);
    send_target(8'd101);
    send_target(8'hFF);
    send_target(8'd1);
    send_target(8'd0);
    settle();
  endtask

  // Step sizes zero, just below the minimum, and the largest
  task automatic test_step_extremes();
    write_reg(REG_RAMP_STEP, 8'd0);
    send_target(8'd100);
    send_target(8'd0);
    settle();
    write_reg(REG_RAMP_STEP, 8'd4);
    send_target(8'd60);
    send_target(8'd0);
    settle();
    write_reg(REG_RAMP_STEP, 8'd255);
    send_target(8'd100);
    send_target(8'd20);
    settle();
  endtask

  // Soft maximum and dead zone at their extremes, upper register bit set
  task automatic test_scale_extremes();
    write_reg(REG_RAMP_STEP, MIN_STEP_SIZE);
    write_reg(REG_SOFT_MAX, 8'd0);
    send_target(8'd100);
    settle();
    write_reg(REG_SOFT_MAX, 8'hFF);
    write_reg(REG_DEAD_ZONE, 8'd0);
    send_target(8'd1);
    send_target(8'd100);
    send_target(8'd0);
    settle();
    write_reg(REG_DEAD_ZONE, 8'd100);
    send_target(8'd99);
    send_target(8'd100);
    settle();
    write_reg(REG_DEAD_ZONE, 8'hFF);
    send_target(8'd100);
    send_target(8'd0);
    settle();
  endtask

  function automatic logic [7:0] pick_target();
    logic [7:0] v;
    int unsigned c;
    c = $urandom_range(0, 19);
    if (c < 3) v = 8'd0;
    else if (c < 5) v = 8'($urandom_range(128, 255));
    else if (c < 7) v = 8'($urandom_range(101, 127));
    else if (c < 9) v = 8'($urandom_range(1, 15));
    else v = 8'($urandom_range(1, 100));
    return v;
  endfunction

  // New register setting for a phase: mostly usable, sometimes extreme
  task automatic randomise_regs();
    case ($urandom_range(0, 3))
      0: write_reg(REG_DEAD_ZONE, 8'd0);
      1: write_reg(REG_DEAD_ZONE, 8'($urandom_range(0, 30)));
      2: write_reg(REG_DEAD_ZONE, 8'($urandom_range(0, 255)));
      default: write_reg(REG_DEAD_ZONE, 8'(DEAD_ZONE_RESET));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_SOFT_MAX, 8'd100);
      1: write_reg(REG_SOFT_MAX, 8'($urandom_range(0, 255)));
      default: write_reg(REG_SOFT_MAX, 8'($urandom_range(50, 127)));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_RAMP_STEP, 8'($urandom_range(0, 255)));
      1: write_reg(REG_RAMP_STEP, 8'($urandom_range(20, 80)));
      default: write_reg(REG_RAMP_STEP, 8'($urandom_range(5, 12)));
    endcase
  endtask

  // Random commands: mostly stop-and-climb sequences, the rest noise
  task automatic test_random_commands();
    int unsigned sent;
    int unsigned phase_sent;
    int unsigned len;
    logic [7:0] level;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      randomise_regs();
      idling_on = (RANDOM_ITEMS - sent > PHASE_ITEMS);
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 9) < 6) begin
          len = $urandom_range(2, 5);
          send_target(8'd0);
          level = 8'd0;
          for (int unsigned k = 1; k < len; k++) begin
            level = level + 8'($urandom_range(1, 40));
            if (level > 8'd110) level = 8'($urandom_range(95, 127));
            send_target(level);
          end
          sent += len;
          phase_sent += len;
        end else begin
          send_target(pick_target());
          sent++;
          phase_sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    dead_zone_m = DEAD_ZONE_RESET;
    soft_max_m = SOFT_MAX_RESET;
    step_m = RAMP_STEP_RESET;
    speed_m = 7'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_defaults();
    idling_on = 1'b1;
    test_step_extremes();
    test_scale_extremes();
    test_random_commands();

    $display("Run covered %0d targets, %0d duty beats and %0d register writes,",
             items_accepted, beats_checked, cfg_writes);
    $display("with clamping, dead zone, soft maximum and ramp step extremes; %0d errors.",
             errors);
    if (errors == 0 && duty_beats_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/mdr_pkg.sv
design/mdr_div.sv
design/mdr_front.sv
design/mdr_back.sv
design/motor_duty_soft_start_ramp_top.sv
test/tb_top.sv
